FILE: rtl/core/pfc_pkg.sv
// shared types and constants for the packet framer with crc-16 trailer
package pfc_pkg;

	localparam int QueueDepth = 4;

	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] REG_CRC_POLY = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] REG_CRC_SEED = CfgIdxW'(1);

	localparam logic [15:0] CRC_POLY_RST = 16'h1021;
	localparam logic [15:0] CRC_SEED_RST = 16'h0000;

	localparam logic [7:0] START_SHORT = 8'd2;
	localparam logic [7:0] START_LONG  = 8'd3;
	localparam logic [7:0] STOP_BYTE   = 8'd3;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] payload_length;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
	} result_t;

	// one classified payload byte, handed from front to back
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        is_first;
		logic        long_len;
		logic [15:0] length;
		logic        is_last;
		logic [15:0] crc;
	} cmd_t;

endpackage

FILE: rtl/core/pfc_front.sv
// front end: config registers, frame tracking, crc fold and word classification
module pfc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pfc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [pfc_pkg::CfgDataW-1:0] cfg_data,
	input  logic                         accept,
	input  pfc_pkg::item_t               item,
	output pfc_pkg::cmd_t                cmd
);
	import pfc_pkg::*;

	logic [15:0] crc_poly_q;
	logic [15:0] crc_seed_q;
	logic [15:0] bytes_left_q;
	logic [15:0] crc_q;

	logic        first;
	logic [15:0] len;
	logic [15:0] crc_in;
	logic [15:0] crc_new;
	logic [15:0] left_new;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b,
			input logic [15:0] poly);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ poly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	always_comb begin
		first    = (bytes_left_q == 16'd0);
		len      = (item.payload_length == 16'd0) ? 16'd1 : item.payload_length;
		crc_in   = first ? crc_seed_q : crc_q;
		crc_new  = crc_fold(crc_in, item.data_byte, crc_poly_q);
		left_new = (first ? len : bytes_left_q) - 16'd1;

		cmd.data_byte = item.data_byte;
		cmd.is_first  = first;
		cmd.long_len  = (len[15:8] != 8'd0);
		cmd.length    = len;
		cmd.is_last   = (left_new == 16'd0);
		cmd.crc       = crc_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q   <= CRC_POLY_RST;
			crc_seed_q   <= CRC_SEED_RST;
			bytes_left_q <= 16'd0;
			crc_q        <= 16'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CRC_POLY: crc_poly_q <= cfg_data[15:0];
					REG_CRC_SEED: crc_seed_q <= cfg_data[15:0];
					default:      ;
				endcase
			end
			if (accept) begin
				bytes_left_q <= left_new;
				crc_q        <= crc_new;
			end
		end
	end

endmodule

FILE: rtl/core/pfc_queue.sv
// small command queue between the front and back ends
module pfc_queue #(
	parameter int Depth = pfc_pkg::QueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  pfc_pkg::cmd_t wr_cmd,
	input  logic          rd,
	output pfc_pkg::cmd_t rd_cmd,
	output logic          full,
	output logic          empty
);
	import pfc_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full   = (count_q == CntW'(Depth));
	assign empty  = (count_q == '0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && !empty;
	assign rd_cmd = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/pfc_back.sv
// back end: expands commands into header, payload and trailer bytes
module pfc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  pfc_pkg::cmd_t    cmd,
	input  logic             q_empty,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output pfc_pkg::result_t result
);
	import pfc_pkg::*;

	localparam logic [2:0] ST_BEGIN  = 3'd0;
	localparam logic [2:0] ST_START  = 3'd1;
	localparam logic [2:0] ST_LEN_HI = 3'd2;
	localparam logic [2:0] ST_LEN_LO = 3'd3;
	localparam logic [2:0] ST_DATA   = 3'd4;
	localparam logic [2:0] ST_CRC_HI = 3'd5;
	localparam logic [2:0] ST_CRC_LO = 3'd6;
	localparam logic [2:0] ST_STOP   = 3'd7;

	logic [2:0] step_q;
	logic       out_valid_q;
	result_t    out_q;

	logic       adv;
	logic       load;
	logic [2:0] cur;
	logic [2:0] nxt;
	logic       done;
	result_t    word;

	assign adv  = !out_valid_q || pop;
	assign load = adv && !q_empty;

	always_comb begin
		if (step_q == ST_BEGIN) begin
			cur = cmd.is_first ? ST_START : ST_DATA;
		end else begin
			cur = step_q;
		end

		word.frame_end = 1'b0;
		nxt            = ST_BEGIN;
		done           = 1'b0;
		case (cur)
			ST_START: begin
				word.out_byte = cmd.long_len ? START_LONG : START_SHORT;
				nxt           = cmd.long_len ? ST_LEN_HI : ST_LEN_LO;
			end
			ST_LEN_HI: begin
				word.out_byte = cmd.length[15:8];
				nxt           = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				word.out_byte = cmd.length[7:0];
				nxt           = ST_DATA;
			end
			ST_DATA: begin
				word.out_byte = cmd.data_byte;
				nxt           = cmd.is_last ? ST_CRC_HI : ST_BEGIN;
				done          = !cmd.is_last;
			end
			ST_CRC_HI: begin
				word.out_byte = cmd.crc[15:8];
				nxt           = ST_CRC_LO;
			end
			ST_CRC_LO: begin
				word.out_byte = cmd.crc[7:0];
				nxt           = ST_STOP;
			end
			ST_STOP: begin
				word.out_byte  = STOP_BYTE;
				word.frame_end = 1'b1;
				done           = 1'b1;
			end
			default: begin
				word.out_byte = cmd.data_byte;
				done          = 1'b1;
			end
		endcase
	end

	assign q_pop  = load && done;
	assign empty  = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_BEGIN;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= !q_empty;
			end
			if (load) begin
				step_q <= done ? ST_BEGIN : nxt;
			end
		end
	end

endmodule

FILE: rtl/core/packet_framer_crc16_top.sv
// top level of the length-prefixed packet framer with crc-16 trailer
//
// input channel: one payload word per push, accepted when push is high and
// full is low. payload_length is sampled only on the first word of a frame;
// a length of zero counts as one.
// result channel: queue style; while empty is low the oldest framed byte sits
// on result, and pop takes it. frame_end marks the stop byte.
// each payload word yields one to six bytes: header (start plus one or two
// length bytes) on a frame's first word, the payload byte, and on the last
// word the crc high, crc low and stop bytes.
// an accepted word passes the command queue and then the output register.
// throughput: the front takes one word per cycle while full is low; the back
// end puts out one byte per cycle while pop is high, so the output port sets
// the sustained rate: one word per cycle mid-frame, plus header and trailer.
// a short command queue lets the front keep taking words while the receiver
// stalls; full rises only once the queue has filled.
// config: write cfg_data to register cfg_index (0 crc_poly, 1 crc_seed) with
// cfg_we, only while the block is idle.
// reset: clears frame tracking, the crc, the queue and the output valid flag,
// and loads the default polynomial 0x1021 and seed 0.
module packet_framer_crc16_top #(
	parameter int QueueDepth = pfc_pkg::QueueDepth
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pfc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [pfc_pkg::CfgDataW-1:0] cfg_data,
	input  logic                         push,
	output logic                         full,
	input  pfc_pkg::item_t               item,
	output logic                         empty,
	input  logic                         pop,
	output pfc_pkg::result_t             result
);
	import pfc_pkg::*;

	// words cross from front to back through the queue
	cmd_t front_cmd;
	cmd_t head_cmd;
	logic accept;
	logic q_empty;
	logic q_pop;

	assign accept = push && !full;

	// classify each word and fold it into the crc
	pfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (item),
		.cmd       (front_cmd)
	);

	// decouples word intake from byte output
	pfc_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wr_cmd (front_cmd),
		.rd     (q_pop),
		.rd_cmd (head_cmd),
		.full   (full),
		.empty  (q_empty)
	);

	// serialize header, payload and trailer into the output register
	pfc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (head_cmd),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

FILE: rtl/core/pfc_checker.sv
// port-level checks for the packet framer, bound to the top level
module pfc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             push,
	input logic             full,
	input logic             empty,
	input logic             pop,
	input pfc_pkg::result_t result
);
	import pfc_pkg::*;

	// high when the next shown byte must open a frame
	logic expect_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_start_q <= 1'b1;
		end else if (!empty && pop) begin
			expect_start_q <= result.frame_end;
		end
	end

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while stalled");

	a_frame_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && expect_start_q) |->
		(result.out_byte == START_SHORT || result.out_byte == START_LONG))
		else $error("frame does not open with a start byte");

	a_full_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("queue full with no output pending");

	a_push_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && empty) |=> ##1 !empty)
		else $error("accepted word not shown in time");

endmodule

bind packet_framer_crc16_top pfc_checker u_pfc_checker (.*);

FILE: tb/packet_framer_crc16_top_tb.sv
// self-checking testbench for the packet framer with crc-16 trailer
`timescale 1ns / 1ps

module packet_framer_crc16_top_tb;
	import pfc_pkg::*;

	// longest run of cycles with no word moving on either side
	localparam int QuietLimit = 4000;
	localparam logic [15:0] ShortLenMax = 16'd255;
	localparam int ReportMax = 10;

	// expected wire bytes, built from the payload words the block has taken
	class framer_scoreboard;
		logic [15:0] poly;
		logic [15:0] seed;
		logic [15:0] bytes_left;
		logic [15:0] crc;
		result_t bytes_due[$];
		int unsigned errors;

		function new();
			poly = CRC_POLY_RST;
			seed = CRC_SEED_RST;
			bytes_left = '0;
			crc = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
			case (idx)
				REG_CRC_POLY: poly = val;
				REG_CRC_SEED: seed = val;
				default: ;
			endcase
		endfunction

		// msb-first crc-16 over one byte with the current polynomial
		function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			r = c ^ {b, 8'h00};
			for (int i = 0; i < 8; i++)
				r = r[15] ? ((r << 1) ^ poly) : (r << 1);
			return r;
		endfunction

		function void due(logic [7:0] b, logic e);
			result_t r;
			r.out_byte = b;
			r.frame_end = e;
			bytes_due.push_back(r);
		endfunction

		function void note_word(item_t w);
			logic [15:0] len;
			if (bytes_left == '0) begin
				// zero length counts as one
				len = (w.payload_length == '0) ? 16'd1 : w.payload_length;
				crc = seed;
				if (len <= ShortLenMax) begin
					due(START_SHORT, 1'b0);
					due(len[7:0], 1'b0);
				end else begin
					due(START_LONG, 1'b0);
					due(len[15:8], 1'b0);
					due(len[7:0], 1'b0);
				end
				bytes_left = len;
			end
			due(w.data_byte, 1'b0);
			crc = crc_step(crc, w.data_byte);
			bytes_left = bytes_left - 16'd1;
			if (bytes_left == '0) begin
				due(crc[15:8], 1'b0);
				due(crc[7:0], 1'b0);
				due(STOP_BYTE, 1'b1);
			end
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (bytes_due.size() == 0) begin
				errors++;
				if (errors <= ReportMax)
					$display("unexpected byte %02h end %0b", got.out_byte, got.frame_end);
				return;
			end
			exp = bytes_due.pop_front();
			if (got.out_byte !== exp.out_byte || got.frame_end !== exp.frame_end) begin
				errors++;
				if (errors <= ReportMax)
					$display("mismatch: expected byte %02h end %0b, got byte %02h end %0b",
						exp.out_byte, exp.frame_end, got.out_byte, got.frame_end);
			end
		endfunction

		function int pending();
			return bytes_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic push;
	logic full;
	item_t item;
	logic empty;
	logic pop;
	result_t result;

	framer_scoreboard sb = new();

	// idle odds in percent for each side, changed per phase
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;

	packet_framer_crc16_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: pop decided at the falling edge, result taken at the rising edge
	initial begin
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				sb.check_result(result);
			@(negedge clk);
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog: any word moving on either side restarts the count
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// one payload word; called and left at a falling edge
	task automatic send_word(input item_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= w;
		do
			@(posedge clk);
		while (full);
		sb.note_word(w);
		@(negedge clk);
	endtask

	// first word carries len_field; later words carry random, ignored lengths
	task automatic send_frame(input logic [15:0] len_field, input int words);
		item_t w;
		for (int i = 0; i < words; i++) begin
			w.data_byte = 8'($urandom);
			w.payload_length = (i == 0) ? len_field : 16'($urandom);
			send_word(w);
		end
	endtask

	// hold the sender until every expected byte has come, plus a short tail
	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// both registers in two back-to-back writes; block must be idle
	task automatic write_cfg(input logic [15:0] poly, input logic [15:0] seed);
		cfg_we <= 1'b1;
		cfg_index <= REG_CRC_POLY;
		cfg_data <= poly;
		@(negedge clk);
		sb.set_reg(REG_CRC_POLY, poly);
		cfg_index <= REG_CRC_SEED;
		cfg_data <= seed;
		@(negedge clk);
		sb.set_reg(REG_CRC_SEED, seed);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// random frames, mostly short; one big frame dropped in halfway if asked
	task automatic run_phase(input int s_idle, input int r_idle, input int words,
		input logic [15:0] big_len);
		int sent;
		int pick;
		bit big_done;
		logic [15:0] len;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		sent = 0;
		big_done = (big_len == '0);
		while (sent < words || !big_done) begin
			// now and then let the pipe run dry mid-stream
			if ($urandom_range(19) == 0)
				settle();
			pick = $urandom_range(99);
			if (!big_done && sent >= words / 2) begin
				len = big_len;
				big_done = 1'b1;
			end else if (pick < 5)
				len = '0;
			else if (pick < 75)
				len = 16'($urandom_range(8, 1));
			else if (pick < 95)
				len = 16'($urandom_range(24, 9));
			else
				len = 16'($urandom_range(60, 25));
			send_frame(len, (len == '0) ? 1 : int'(len));
			sent += (len == '0) ? 1 : int'(len);
		end
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CRC_POLY;
		cfg_data = '0;
		push = 1'b0;
		item = '0;
		send_idle_pct = 30;
		recv_idle_pct = 59;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: default xmodem settings first
		// zero length becomes a one-byte frame
		send_word('{data_byte: 8'h00, payload_length: 16'h0000});
		send_word('{data_byte: 8'hFF, payload_length: 16'h0001});
		// length on the second word is ignored, all ones there
		send_word('{data_byte: 8'hA5, payload_length: 16'h0002});
		send_word('{data_byte: 8'h5A, payload_length: 16'hFFFF});
		send_frame(16'd3, 3);

		// register change in the middle of a frame: polynomial applies from the
		// next byte, seed waits for the next frame
		send_frame(16'd6, 3);
		settle();
		write_cfg(16'h8005, 16'hFFFF);
		send_frame(16'd6, 3);
		send_frame(16'd2, 2);
		settle();

		// extremes of both registers
		write_cfg(16'h0000, 16'h0000);
		send_frame(16'd2, 2);
		settle();
		write_cfg(16'hFFFF, 16'hFFFF);
		send_word('{data_byte: 8'hFF, payload_length: 16'h0002});
		send_word('{data_byte: 8'h00, payload_length: 16'h0000});
		settle();

		// random phases; the largest one-byte length gets one full frame
		write_cfg(16'($urandom), 16'($urandom));
		run_phase(30, 59, 60, ShortLenMax);
		write_cfg(CRC_POLY_RST, CRC_SEED_RST);
		run_phase(59, 30, 70, '0);
		write_cfg(16'($urandom), 16'($urandom));
		run_phase(0, 0, 70, '0);

		// smallest two-byte length last: header checked, frame left open
		send_frame(ShortLenMax + 16'd1, 3);
		settle();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
